FILE: hdl/wrnp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrnp_pkg: shared types and constants of the weighted random node picker
// Command codes, index width, controller states and the structs that travel
// between the controller and the row of weight cells.
// ----------------------------------------------------------------------------
package wrnp_pkg;

    // Width of node_index and picked_node
    localparam int IDX_W = 6;

    // Request commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_PICK  = 1'b1;

    // Controller states, one-hot
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_WRITE = 6'b000010,
        S_MUL   = 6'b000100,
        S_TGT   = 6'b001000,
        S_WALK  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    // Search token flags carried from cell to cell
    typedef struct packed {
        logic             valid;
        logic             hit;
        logic [IDX_W-1:0] idx;
    } t_token;

    // Weight write control broadcast to all cells
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic             active;
    } t_wr_ctl;

endpackage

FILE: hdl/weighted_random_node_picker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_random_node_picker: roulette-wheel selection over node weights
// Write requests store one node's weight and active flag and update the
// total of active weights. Pick requests scale the total by a Q0.16 fraction
// and return the first active node whose prefix sum exceeds the target.
// ----------------------------------------------------------------------------
// Write: after accept the controller passes through S_WRITE and returns to idle.
// Pick: the controller steps through S_MUL, S_TGT, S_WALK and S_DONE; the walk
//   is the search token moving through the row of NODE_COUNT cells one node
//   per cycle. No new request is taken until the result is in the output register.
// Reset clears all active flags, the total and the handshake state.
// ----------------------------------------------------------------------------
module weighted_random_node_picker #(
    parameter int NODE_COUNT    = 64,
    parameter int WEIGHT_BITS   = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_cmd,
    input  logic [wrnp_pkg::IDX_W-1:0]   i_node_index,
    input  logic [WEIGHT_BITS-1:0]       i_weight,
    input  logic                         i_active,
    input  logic [FRACTION_BITS-1:0]     i_random_fraction,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [wrnp_pkg::IDX_W-1:0]   o_picked_node,
    output logic                         o_found
);

    localparam int TOT_W = WEIGHT_BITS + $clog2(NODE_COUNT);
    localparam int LO_W  = (TOT_W + 1) / 2;
    localparam int HI_W  = TOT_W - LO_W;
    localparam int PW    = TOT_W + FRACTION_BITS;

    wrnp_pkg::t_state               r_state, n_state;
    logic [TOT_W-1:0]               r_total, n_total;
    logic [wrnp_pkg::IDX_W-1:0]     r_wr_idx;
    logic [WEIGHT_BITS-1:0]         r_wr_weight;
    logic                           r_wr_active;
    logic [FRACTION_BITS-1:0]       r_frac;
    logic [LO_W+FRACTION_BITS-1:0]  r_p_lo;
    logic [HI_W+FRACTION_BITS-1:0]  r_p_hi;
    logic [TOT_W-1:0]               r_target;
    logic                           r_launch;
    logic [wrnp_pkg::IDX_W-1:0]     r_res_node;
    logic                           r_res_found;
    logic                           r_o_valid;
    logic [wrnp_pkg::IDX_W-1:0]     r_o_node;
    logic                           r_o_found;

    logic                           w_in_acc;
    logic                           w_out_free;
    logic [PW-1:0]                  w_prod;
    wrnp_pkg::t_wr_ctl              w_wr;
    wrnp_pkg::t_token               w_token;
    logic [WEIGHT_BITS-1:0]         w_old;

    assign o_ready    = (r_state == wrnp_pkg::S_IDLE);
    assign w_in_acc   = i_valid && o_ready;
    assign w_out_free = !r_o_valid || i_ready;

    always_comb begin
        w_wr.en     = (r_state == wrnp_pkg::S_WRITE);
        w_wr.idx    = r_wr_idx;
        w_wr.active = r_wr_active;
    end

    wrnp_chain #(
        .NODE_COUNT  (NODE_COUNT),
        .WEIGHT_BITS (WEIGHT_BITS),
        .TOT_W       (TOT_W)
    ) u_chain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (w_wr),
        .i_weight (r_wr_weight),
        .i_target (r_target),
        .i_launch (r_launch),
        .o_token  (w_token),
        .o_old    (w_old)
    );

    // Swap the node's old active weight for its new one
    always_comb begin
        n_total = r_total - TOT_W'(w_old)
                + (r_wr_active ? TOT_W'(r_wr_weight) : TOT_W'(0));
    end

    // Recombine the two partial products; the fraction bits are dropped in S_TGT
    assign w_prod = (PW'(r_p_hi) << LO_W) + PW'(r_p_lo);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wrnp_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_state = (i_cmd == wrnp_pkg::CMD_PICK) ? wrnp_pkg::S_MUL
                                                            : wrnp_pkg::S_WRITE;
                end
            end
            wrnp_pkg::S_WRITE: n_state = wrnp_pkg::S_IDLE;
            wrnp_pkg::S_MUL:   n_state = wrnp_pkg::S_TGT;
            wrnp_pkg::S_TGT:   n_state = wrnp_pkg::S_WALK;
            wrnp_pkg::S_WALK: begin
                if (w_token.valid) begin
                    n_state = wrnp_pkg::S_DONE;
                end
            end
            wrnp_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = wrnp_pkg::S_IDLE;
                end
            end
            default: n_state = wrnp_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= wrnp_pkg::S_IDLE;
            r_total   <= '0;
            r_launch  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_launch <= (r_state == wrnp_pkg::S_TGT);
            if (r_state == wrnp_pkg::S_WRITE) begin
                r_total <= n_total;
            end
            if (r_state == wrnp_pkg::S_DONE && w_out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_wr_idx    <= i_node_index;
            r_wr_weight <= i_weight;
            r_wr_active <= i_active;
            r_frac      <= i_random_fraction;
        end
        if (r_state == wrnp_pkg::S_MUL) begin
            r_p_lo <= (LO_W + FRACTION_BITS)'(r_total[LO_W-1:0])
                    * (LO_W + FRACTION_BITS)'(r_frac);
            r_p_hi <= (HI_W + FRACTION_BITS)'(r_total[TOT_W-1:LO_W])
                    * (HI_W + FRACTION_BITS)'(r_frac);
        end
        if (r_state == wrnp_pkg::S_TGT) begin
            r_target <= w_prod[PW-1:FRACTION_BITS];
        end
        // Hold the search result until the output register is free
        if (r_state == wrnp_pkg::S_WALK && w_token.valid) begin
            r_res_node  <= w_token.hit ? w_token.idx : '0;
            r_res_found <= w_token.hit;
        end
        if (r_state == wrnp_pkg::S_DONE && w_out_free) begin
            r_o_node  <= r_res_node;
            r_o_found <= r_res_found;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_picked_node = r_o_node;
    assign o_found       = r_o_found;

endmodule

FILE: hdl/wrnp_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrnp_cell: one node of the picker
// Holds one node's weight and active flag. A search token is registered in
// the cell: the cell adds its weight to the prefix sum and marks a hit when
// it is the first active node whose prefix exceeds the target.
// ----------------------------------------------------------------------------
module wrnp_cell #(
    parameter int CELL_INDEX  = 0,
    parameter int WEIGHT_BITS = 16,
    parameter int TOT_W       = 22
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  wrnp_pkg::t_wr_ctl      i_wr,
    input  logic [WEIGHT_BITS-1:0] i_weight,
    input  logic [TOT_W-1:0]       i_target,
    input  wrnp_pkg::t_token       i_token,
    input  logic [TOT_W-1:0]       i_prefix,
    output wrnp_pkg::t_token       o_token,
    output logic [TOT_W-1:0]       o_prefix,
    output logic [WEIGHT_BITS-1:0] o_old
);

    localparam logic [wrnp_pkg::IDX_W-1:0] OWN_IDX   = wrnp_pkg::IDX_W'(CELL_INDEX);
    localparam logic                       REACHABLE = (CELL_INDEX < 2 ** wrnp_pkg::IDX_W);

    logic [WEIGHT_BITS-1:0] r_weight;
    logic                   r_active;
    wrnp_pkg::t_token       r_token;
    logic [TOT_W-1:0]       r_prefix;

    logic                   w_sel;
    logic [WEIGHT_BITS-1:0] w_contrib;
    logic [TOT_W-1:0]       n_prefix;
    logic                   w_hit_here;
    wrnp_pkg::t_token       n_token;

    always_comb begin
        w_sel      = REACHABLE && (i_wr.idx == OWN_IDX);
        w_contrib  = r_active ? r_weight : '0;
        n_prefix   = i_prefix + TOT_W'(w_contrib);
        w_hit_here = i_token.valid && !i_token.hit && r_active && (n_prefix > i_target);
        n_token.valid = i_token.valid;
        n_token.hit   = i_token.hit || w_hit_here;
        n_token.idx   = w_hit_here ? OWN_IDX : i_token.idx;
    end

    // Contribution before the pending write, for the running total
    assign o_old = (w_sel && r_active) ? r_weight : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_token  <= '0;
        end else begin
            if (i_wr.en && w_sel) begin
                r_active <= i_wr.active;
            end
            r_token <= n_token;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && w_sel) begin
            r_weight <= i_weight;
        end
        r_prefix <= n_prefix;
    end

    assign o_token  = r_token;
    assign o_prefix = r_prefix;

endmodule

FILE: hdl/wrnp_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrnp_chain: row of node cells
// Links the cells so a search token moves one node per cycle, and merges the
// old contribution of the node addressed by a pending write.
// ----------------------------------------------------------------------------
module wrnp_chain #(
    parameter int NODE_COUNT  = 64,
    parameter int WEIGHT_BITS = 16,
    parameter int TOT_W       = 22
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  wrnp_pkg::t_wr_ctl      i_wr,
    input  logic [WEIGHT_BITS-1:0] i_weight,
    input  logic [TOT_W-1:0]       i_target,
    input  logic                   i_launch,
    output wrnp_pkg::t_token       o_token,
    output logic [WEIGHT_BITS-1:0] o_old
);

    wrnp_pkg::t_token       w_token  [NODE_COUNT+1];
    logic [TOT_W-1:0]       w_prefix [NODE_COUNT+1];
    logic [WEIGHT_BITS-1:0] w_old    [NODE_COUNT];

    // Fresh token enters at the head with an empty prefix
    assign w_token[0]  = '{valid: i_launch, hit: 1'b0, idx: '0};
    assign w_prefix[0] = '0;

    for (genvar g = 0; g < NODE_COUNT; g++) begin : g_cell
        wrnp_cell #(
            .CELL_INDEX  (g),
            .WEIGHT_BITS (WEIGHT_BITS),
            .TOT_W       (TOT_W)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_wr     (i_wr),
            .i_weight (i_weight),
            .i_target (i_target),
            .i_token  (w_token[g]),
            .i_prefix (w_prefix[g]),
            .o_token  (w_token[g+1]),
            .o_prefix (w_prefix[g+1]),
            .o_old    (w_old[g])
        );
    end

    // At most one cell is addressed, so an OR merges the old weights
    always_comb begin
        o_old = '0;
        for (int k = 0; k < NODE_COUNT; k++) begin
            o_old = o_old | w_old[k];
        end
    end

    assign o_token = w_token[NODE_COUNT];

endmodule

FILE: verif/weighted_random_node_picker_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_random_node_picker_test: self-checking bench for the node picker
// Sends write and pick requests through the valid/ready handshake and keeps
// its own copy of the weight table, the active flags and the active total.
// Every accepted pick gets a predicted node and found flag. Each returned
// result is checked in order, under several patterns of input gaps and
// output stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module weighted_random_node_picker_test;

    localparam int NODES        = 64;
    localparam int WT_W         = 16;
    localparam int FRAC_W       = 16;
    localparam int IDX_W        = wrnp_pkg::IDX_W;
    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 2 * (NODES + 4);
    localparam int HOLD_CYCLES  = 800;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [IDX_W-1:0] node;
        logic             found;
    } t_pick;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              req_valid  = 1'b0;
    logic              req_ready;
    logic              req_cmd    = wrnp_pkg::CMD_WRITE;
    logic [IDX_W-1:0]  req_node   = '0;
    logic [WT_W-1:0]   req_weight = '0;
    logic              req_active = 1'b0;
    logic [FRAC_W-1:0] req_frac   = '0;
    logic              res_valid;
    logic              res_ready  = 1'b0;
    logic [IDX_W-1:0]  res_node;
    logic              res_found;

    // Local copy of the block's table
    logic [WT_W-1:0]   node_wt [NODES];
    logic              node_on [NODES];
    logic [31:0]       active_total;

    t_pick             pick_queue[$];

    int                send_idle_pct = 0;
    int                rx_stall_pct  = 0;
    logic              hold_rx       = 1'b0;
    event              hold_rx_go;

    int                err_count = 0;
    int                n_writes  = 0;
    int                n_picks   = 0;
    int                n_found   = 0;
    int                cycle_cnt = 0;

    always #4 clk = ~clk;

    weighted_random_node_picker #(
        .NODE_COUNT    (NODES),
        .WEIGHT_BITS   (WT_W),
        .FRACTION_BITS (FRAC_W)
    ) u_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_valid           (req_valid),
        .o_ready           (req_ready),
        .i_cmd             (req_cmd),
        .i_node_index      (req_node),
        .i_weight          (req_weight),
        .i_active          (req_active),
        .i_random_fraction (req_frac),
        .o_valid           (res_valid),
        .i_ready           (res_ready),
        .o_picked_node     (res_node),
        .o_found           (res_found)
    );

    // Roulette walk: first active node whose prefix sum exceeds the target
    function automatic t_pick predict_pick(input logic [FRAC_W-1:0] frac);
        logic [63:0] target;
        logic [63:0] prefix;
        t_pick       res;
        target = (64'(active_total) * 64'(frac)) >> FRAC_W;
        prefix = '0;
        res    = '0;
        for (int n = 0; n < NODES; n++) begin
            if (node_on[n] && !res.found) begin
                prefix += 64'(node_wt[n]);
                if (prefix > target) begin
                    res.node  = IDX_W'(n);
                    res.found = 1'b1;
                end
            end
        end
        return res;
    endfunction

    function automatic logic [WT_W-1:0] rand_weight();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return WT_W'($urandom_range(1, 15));
            default: return WT_W'($urandom);
        endcase
    endfunction

    function automatic logic [FRAC_W-1:0] rand_frac();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return FRAC_W'($urandom);
        endcase
    endfunction

    // Offer one request and hold it until accepted; update the table copy
    task automatic send_request(input logic cmd, input logic [IDX_W-1:0] idx,
                                input logic [WT_W-1:0] wt, input logic act,
                                input logic [FRAC_W-1:0] frac);
        int gap;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 90)
                                              : $urandom_range(1, 4);
            repeat (gap) begin
                req_valid <= 1'b0;
                @(posedge clk);
            end
        end
        req_valid  <= 1'b1;
        req_cmd    <= cmd;
        req_node   <= idx;
        req_weight <= wt;
        req_active <= act;
        req_frac   <= frac;
        do @(posedge clk); while (!req_ready);
        if (cmd == wrnp_pkg::CMD_PICK) begin
            pick_queue.insert(pick_queue.size(), predict_pick(frac));
            n_picks++;
        end else begin
            if (node_on[idx])
                active_total -= 32'(node_wt[idx]);
            node_wt[idx] = wt;
            node_on[idx] = act;
            if (act)
                active_total += 32'(wt);
            n_writes++;
        end
    endtask

    task automatic send_write(input logic [IDX_W-1:0] idx, input logic [WT_W-1:0] wt,
                              input logic act);
        send_request(wrnp_pkg::CMD_WRITE, idx, wt, act, FRAC_W'($urandom));
    endtask

    task automatic send_pick(input logic [FRAC_W-1:0] frac);
        send_request(wrnp_pkg::CMD_PICK, IDX_W'($urandom), WT_W'($urandom), 1'($urandom),
                     frac);
    endtask

    task automatic test_empty_table();
        send_idle_pct = 0;
        rx_stall_pct  = 0;
        send_pick('0);
        send_pick('1);
    endtask

    task automatic test_weight_boundaries();
        send_write(6'd63, 16'hFFFF, 1'b1);
        send_pick('0);
        send_pick('1);
        // zero-weight active node ahead of the only weighted one
        send_write(6'd0, 16'h0000, 1'b1);
        send_pick('0);
        // rewrite an active node, then probe both sides of the split point
        send_write(6'd10, 16'h8000, 1'b1);
        send_write(6'd63, 16'h8000, 1'b1);
        send_pick(16'h7FFF);
        send_pick(16'h8000);
        // heavy inactive node must be skipped
        send_write(6'd20, 16'hFFFF, 1'b0);
        send_pick('1);
        // all active weights zero
        send_write(6'd10, 16'h0000, 1'b0);
        send_write(6'd63, 16'h0000, 1'b1);
        send_pick(16'h8000);
        send_write(6'd5, 16'h0001, 1'b1);
        send_pick('1);
        send_write(6'h2A, 16'hAAAA, 1'b1);
        send_write(6'h15, 16'h5555, 1'b1);
        send_pick(16'hAAAA);
        send_pick(16'h5555);
    endtask

    task automatic test_full_table();
        send_idle_pct = 18;
        rx_stall_pct  = 18;
        for (int n = 0; n < NODES; n++)
            send_write(IDX_W'(n), '1, 1'b1);
        send_pick('0);
        send_pick('1);
        for (int k = 0; k < 10; k++)
            send_pick(rand_frac());
    endtask

    task automatic test_random_traffic(input int count, input int idle_pct,
                                       input int stall_pct);
        logic [IDX_W-1:0] idx;
        send_idle_pct = idle_pct;
        rx_stall_pct  = stall_pct;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < 45) begin
                // bias toward both ends of the table so nodes get rewritten
                case ($urandom_range(0, 3))
                    0: idx = IDX_W'($urandom_range(0, 7));
                    1: idx = IDX_W'($urandom_range(NODES - 8, NODES - 1));
                    default: idx = IDX_W'($urandom);
                endcase
                send_write(idx, rand_weight(), $urandom_range(0, 3) != 0);
            end else begin
                send_pick(rand_frac());
            end
        end
    endtask

    task automatic test_output_backpressure();
        send_idle_pct = 0;
        rx_stall_pct  = 0;
        -> hold_rx_go;
        for (int k = 0; k < 8; k++)
            send_pick(rand_frac());
    endtask

    // Long output hold-off, counted here
    always begin
        @(hold_rx_go);
        hold_rx <= 1'b1;
        for (int c = 0; c < HOLD_CYCLES; c++)
            @(posedge clk);
        hold_rx <= 1'b0;
    end

    // Drive result ready and check each accepted result against the oldest pick
    always @(posedge clk) begin
        t_pick got;
        t_pick want;
        if (!rst_n) begin
            res_ready <= 1'b0;
        end else begin
            res_ready <= !hold_rx && ($urandom_range(0, 99) >= rx_stall_pct);
            if (res_valid && res_ready) begin
                got.node  = res_node;
                got.found = res_found;
                if (pick_queue.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("ERROR @%0t: result node=%0d found=%0b with no pick pending",
                                 $realtime, got.node, got.found);
                end else begin
                    want = pick_queue.pop_front();
                    if (got.found !== want.found || got.node !== want.node) begin
                        err_count++;
                        if (err_count <= MAX_REPORTS)
                            $display("ERROR @%0t: expected node=%0d found=%0b, got %0d %0b",
                                     $realtime, want.node, want.found, got.node, got.found);
                    end
                    if (got.found === 1'b1)
                        n_found++;
                end
            end
        end
    end

    initial begin
        while (cycle_cnt < LIMIT_CYCLES) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("Timeout after %0d cycles, %0d picks still pending",
                 cycle_cnt, pick_queue.size());
        $display("Some tests failed");
        $finish;
    end

    initial begin
        for (int n = 0; n < NODES; n++) begin
            node_wt[n] = '0;
            node_on[n] = 1'b0;
        end
        active_total = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_weight_boundaries();
        test_full_table();
        test_random_traffic(150, 0, 0);
        test_random_traffic(150, 64, 0);
        test_random_traffic(150, 0, 64);
        test_random_traffic(150, 18, 18);
        test_output_backpressure();

        req_valid <= 1'b0;
        while (pick_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d writes and %0d picks (%0d found, %0d not found)",
                 n_writes, n_picks, n_found, n_picks - n_found);
        $display("Covered empty/full tables, split points, gaps, stalls, hold-off: %0d errors",
                 err_count);
        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
